>>> rtl/core/ihf_pkg.sv
// shared types, constants and helpers of the intel hex record formatter
package ihf_pkg;

	localparam int ADDR_W        = 16;
	localparam int NXT_W         = ADDR_W + 1;
	localparam int REC_BYTES_DEF = 32;
	localparam int REC_BYTES_MAX = 255;
	// reciprocal shift, exact for any 17-bit address and any record size up to the max
	localparam int DIV_K         = NXT_W + $clog2(REC_BYTES_MAX + 1);

	localparam logic MODE_DATA = 1'b0;
	localparam logic MODE_END  = 1'b1;

	typedef logic [7:0] char_t;

	localparam char_t CHR_COLON     = 8'h3A;
	localparam char_t CHR_CR        = 8'h0D;
	localparam char_t CHR_LF        = 8'h0A;
	localparam char_t REC_TYPE_DATA = 8'h00;
	localparam char_t REC_TYPE_EOF  = 8'h01;

	localparam logic [1:0] CNT_ONE = 2'd1;
	localparam logic [1:0] CNT_TWO = 2'd2;

	localparam char_t HEX_DIGITS [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
	};

	// one or two characters handed from the sequencer to the packer
	typedef struct packed {
		char_t c0;
		char_t c1;
		logic  two;
		logic  last;
	} sym_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_APPEND,
		S_COLON,
		S_COUNT,
		S_ADDR_HI,
		S_ADDR_LO,
		S_TYPE,
		S_DATA,
		S_SUM,
		S_CRLF
	} seq_state_t;

	function automatic char_t hex_char(input logic [3:0] nib);
		return HEX_DIGITS[nib];
	endfunction

endpackage

>>> rtl/core/ihf_ifs.sv
// valid/ready channel interfaces of the intel hex record formatter
interface ihf_in_if;
	import ihf_pkg::*;

	logic              valid;
	logic              ready;
	logic              mode;
	logic [ADDR_W-1:0] address;
	logic [7:0]        data_byte;

	modport source(output valid, output mode, output address, output data_byte, input ready);
	modport sink(input valid, input mode, input address, input data_byte, output ready);
endinterface

interface ihf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] first_char;
	logic [7:0] second_char;
	logic [1:0] char_count;
	logic       last_of_run;

	modport source(output valid, output first_char, output second_char, output char_count,
		output last_of_run, input ready);
	modport sink(input valid, input first_char, input second_char, input char_count,
		input last_of_run, output ready);
endinterface

>>> rtl/core/ihf_ram.sv
// generic single write port ram with registered read
module ihf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

>>> rtl/core/ihf_seq.sv
// record sequencer: buffer bookkeeping, checksum, 1 hex pair/cycle if ready
module ihf_seq #(
	parameter int RECORD_BYTES = ihf_pkg::REC_BYTES_DEF,
	localparam int IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	ihf_in_if.sink           image,
	output logic             sym_valid,
	input  logic             sym_ready,
	output ihf_pkg::sym_t    sym,
	output logic             wr_en,
	output logic [IDX_W-1:0] wr_addr,
	output logic [7:0]       wr_data,
	output logic [IDX_W-1:0] rd_addr,
	input  logic [7:0]       rd_data
);
	import ihf_pkg::*;

	localparam int FILL_W = $clog2(RECORD_BYTES + 1);
	localparam int M_W    = DIV_K + 1;
	localparam int QP_W   = NXT_W + M_W;
	localparam int PROD_W = NXT_W + 8;
	localparam logic [M_W-1:0] DIV_M =
		M_W'(((longint'(1) << DIV_K) + longint'(RECORD_BYTES) - 1) / longint'(RECORD_BYTES));

	seq_state_t state_q, state_d;

	logic              mode_q;
	logic              eof_q;
	logic              pass_q;
	logic [ADDR_W-1:0] addr_q;
	logic [7:0]        byte_q;
	logic [NXT_W-1:0]  nxt_q;
	logic [NXT_W-1:0]  quo_q;
	logic [FILL_W-1:0] fill_q;
	logic [ADDR_W-1:0] start_q;
	logic [NXT_W-1:0]  next_q;
	logic [7:0]        sum_q, sum_d;
	logic [IDX_W-1:0]  idx_q, idx_d;

	logic              accept;
	logic              flush_first;
	logic [NXT_W-1:0]  in_nxt;
	logic [QP_W-1:0]   quo_prod;
	logic [PROD_W-1:0] chk_prod;
	logic              div_hit;
	logic [FILL_W-1:0] fill_new;
	logic              close_now;
	logic              close_fresh;
	logic              last_data;
	logic              last_rec;
	logic              sym_fire;
	logic              is_byte;
	logic [7:0]        cur_byte;
	logic              do_append;
	logic              rec_done;
	logic              start_eof;

	assign accept = image.valid && image.ready;
	assign in_nxt = {1'b0, image.address} + NXT_W'(1);
	// quotient by reciprocal multiply, checked against the record size later
	assign quo_prod = QP_W'(in_nxt) * QP_W'(DIV_M);
	assign flush_first = (fill_q != '0) &&
		((image.mode == MODE_END) || ({1'b0, image.address} != next_q));

	assign chk_prod    = PROD_W'(quo_q) * PROD_W'(RECORD_BYTES);
	assign div_hit     = chk_prod == PROD_W'(nxt_q);
	assign fill_new    = fill_q + FILL_W'(1);
	assign close_now   = div_hit || (fill_new == FILL_W'(RECORD_BYTES));
	assign close_fresh = div_hit || (RECORD_BYTES == 1);
	assign last_data   = FILL_W'(idx_q) == (fill_q - FILL_W'(1));
	assign last_rec    = eof_q || pass_q || ((mode_q == MODE_DATA) && !close_fresh);
	assign sym_fire    = sym_valid && sym_ready;

	assign wr_en   = do_append;
	assign wr_addr = fill_q[IDX_W-1:0];
	assign wr_data = byte_q;
	assign rd_addr = idx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		image.ready = 1'b0;
		sym_valid   = 1'b0;
		is_byte     = 1'b0;
		cur_byte    = '0;
		do_append   = 1'b0;
		rec_done    = 1'b0;
		start_eof   = 1'b0;
		idx_d       = '0;
		unique case (state_q)
			S_IDLE: begin
				image.ready = 1'b1;
				if (accept) begin
					if (flush_first || image.mode == MODE_END) begin
						state_d = S_COLON;
					end else begin
						state_d = S_APPEND;
					end
				end
			end
			S_APPEND: begin
				do_append = 1'b1;
				state_d   = close_now ? S_COLON : S_IDLE;
			end
			S_COLON: begin
				sym_valid = 1'b1;
				if (sym_fire) state_d = S_COUNT;
			end
			S_COUNT: begin
				sym_valid = 1'b1;
				is_byte   = 1'b1;
				cur_byte  = eof_q ? 8'h00 : 8'(fill_q);
				if (sym_fire) state_d = S_ADDR_HI;
			end
			S_ADDR_HI: begin
				sym_valid = 1'b1;
				is_byte   = 1'b1;
				cur_byte  = eof_q ? 8'h00 : start_q[15:8];
				if (sym_fire) state_d = S_ADDR_LO;
			end
			S_ADDR_LO: begin
				sym_valid = 1'b1;
				is_byte   = 1'b1;
				cur_byte  = eof_q ? 8'h00 : start_q[7:0];
				if (sym_fire) state_d = S_TYPE;
			end
			S_TYPE: begin
				sym_valid = 1'b1;
				is_byte   = 1'b1;
				cur_byte  = eof_q ? REC_TYPE_EOF : REC_TYPE_DATA;
				if (sym_fire) state_d = eof_q ? S_SUM : S_DATA;
			end
			S_DATA: begin
				sym_valid = 1'b1;
				is_byte   = 1'b1;
				cur_byte  = rd_data;
				idx_d     = idx_q;
				if (sym_fire) begin
					if (last_data) begin
						idx_d   = '0;
						state_d = S_SUM;
					end else begin
						idx_d = idx_q + IDX_W'(1);
					end
				end
			end
			S_SUM: begin
				sym_valid = 1'b1;
				is_byte   = 1'b1;
				cur_byte  = ~sum_q + 8'd1;
				if (sym_fire) state_d = S_CRLF;
			end
			S_CRLF: begin
				sym_valid = 1'b1;
				if (sym_fire) begin
					rec_done = 1'b1;
					if (eof_q || pass_q) begin
						state_d = S_IDLE;
					end else if (mode_q == MODE_END) begin
						start_eof = 1'b1;
						state_d   = S_COLON;
					end else begin
						state_d = S_APPEND;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		sym.c0   = hex_char(cur_byte[7:4]);
		sym.c1   = hex_char(cur_byte[3:0]);
		sym.two  = 1'b1;
		sym.last = 1'b0;
		if (state_q == S_COLON) begin
			sym.c0  = CHR_COLON;
			sym.c1  = '0;
			sym.two = 1'b0;
		end else if (state_q == S_CRLF) begin
			sym.c0   = CHR_CR;
			sym.c1   = CHR_LF;
			sym.last = last_rec;
		end

		// running checksum, one byte per hex pair
		sum_d = sum_q;
		if (state_q == S_COLON) begin
			sum_d = '0;
		end else if (is_byte && sym_fire) begin
			sum_d = sum_q + cur_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			start_q <= '0;
			next_q  <= '0;
			eof_q   <= 1'b0;
			pass_q  <= 1'b0;
			mode_q  <= MODE_DATA;
		end else begin
			if (accept) begin
				mode_q <= image.mode;
				eof_q  <= (image.mode == MODE_END) && !flush_first;
				pass_q <= 1'b0;
			end
			if (do_append) begin
				fill_q <= fill_new;
				next_q <= nxt_q;
				if (fill_q == '0) start_q <= addr_q;
				if (close_now) pass_q <= 1'b1;
			end
			if (rec_done && !eof_q) begin
				fill_q <= '0;
			end
			if (start_eof) begin
				eof_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= image.address;
			byte_q <= image.data_byte;
			nxt_q  <= in_nxt;
			quo_q  <= quo_prod[DIV_K +: NXT_W];
		end
		sum_q <= sum_d;
		idx_q <= idx_d;
	end

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(RECORD_BYTES))
		else $error("record fill beyond buffer size");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPEND) |-> (fill_q != FILL_W'(RECORD_BYTES)))
		else $error("append into a full record buffer");

	a_idx_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DATA) |-> (FILL_W'(idx_q) < fill_q))
		else $error("data read beyond record fill");

	a_eof_no_append: assert property (@(posedge clk) disable iff (!arst_n)
		(eof_q && state_q != S_IDLE) |-> (state_q != S_APPEND))
		else $error("append while the end record is in flight");

endmodule

>>> rtl/core/ihf_pack.sv
// packs characters two per word, an odd run end alone; registered output
module ihf_pack (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          sym_valid,
	output logic          sym_ready,
	input  ihf_pkg::sym_t sym,
	ihf_out_if.source     text
);
	import ihf_pkg::*;

	logic       out_valid_q;
	char_t      out_c0_q;
	char_t      out_c1_q;
	logic [1:0] out_cnt_q;
	logic       out_last_q;

	logic       hold_v_q, hold_v_d;
	char_t      hold_c_q, hold_c_d;
	logic       flush_q, flush_d;

	logic       slot_free;
	logic       fire;
	logic       emit;
	char_t      e_c0;
	char_t      e_c1;
	logic [1:0] e_cnt;
	logic       e_last;

	assign slot_free = !out_valid_q || text.ready;
	assign sym_ready = slot_free && !flush_q;
	assign fire      = sym_valid && sym_ready;

	assign text.valid       = out_valid_q;
	assign text.first_char  = out_c0_q;
	assign text.second_char = out_c1_q;
	assign text.char_count  = out_cnt_q;
	assign text.last_of_run = out_last_q;

	always_comb begin
		emit     = 1'b0;
		e_c0     = '0;
		e_c1     = '0;
		e_cnt    = CNT_TWO;
		e_last   = 1'b0;
		hold_v_d = hold_v_q;
		hold_c_d = hold_c_q;
		flush_d  = flush_q;
		if (flush_q) begin
			// leftover odd character closes the run
			if (slot_free) begin
				emit     = 1'b1;
				e_c0     = hold_c_q;
				e_cnt    = CNT_ONE;
				e_last   = 1'b1;
				hold_v_d = 1'b0;
				flush_d  = 1'b0;
			end
		end else if (fire) begin
			if (hold_v_q) begin
				emit   = 1'b1;
				e_c0   = hold_c_q;
				e_c1   = sym.c0;
				e_last = sym.last && !sym.two;
				if (sym.two) begin
					hold_c_d = sym.c1;
					flush_d  = sym.last;
				end else begin
					hold_v_d = 1'b0;
				end
			end else if (sym.two) begin
				emit   = 1'b1;
				e_c0   = sym.c0;
				e_c1   = sym.c1;
				e_last = sym.last;
			end else if (sym.last) begin
				emit   = 1'b1;
				e_c0   = sym.c0;
				e_cnt  = CNT_ONE;
				e_last = 1'b1;
			end else begin
				hold_v_d = 1'b1;
				hold_c_d = sym.c0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hold_v_q    <= 1'b0;
			flush_q     <= 1'b0;
		end else begin
			hold_v_q <= hold_v_d;
			flush_q  <= flush_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (text.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		hold_c_q <= hold_c_d;
		if (emit) begin
			out_c0_q   <= e_c0;
			out_c1_q   <= e_c1;
			out_cnt_q  <= e_cnt;
			out_last_q <= e_last;
		end
	end

	a_flush_has_char: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> hold_v_q)
		else $error("flush pending without a held character");

	a_run_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && sym.last) |=> (!hold_v_q || flush_q))
		else $error("character left behind at end of run");

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> slot_free)
		else $error("output word overwritten before it was taken");

endmodule

>>> rtl/core/intel_hex_record_formatter_top.sv
// intel hex record formatter top level
// a data byte that closes no record gives no output word
// a closed record of n bytes goes out one hex pair per cycle while the packer is ready
// an end item sends the end record, after any flushed record
// reset clears fill, start and next address; the record buffer is not cleared
module intel_hex_record_formatter_top #(
	parameter int RECORD_BYTES = ihf_pkg::REC_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ihf_in_if.sink    image,
	ihf_out_if.source text
);
	import ihf_pkg::*;

	localparam int IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

	sym_t             sym;
	logic             sym_valid;
	logic             sym_ready;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [7:0]       wr_data;
	logic [IDX_W-1:0] rd_addr;
	logic [7:0]       rd_data;

	ihf_seq #(
		.RECORD_BYTES(RECORD_BYTES)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.image    (image),
		.sym_valid(sym_valid),
		.sym_ready(sym_ready),
		.sym      (sym),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data)
	);

	ihf_ram #(
		.WIDTH(8),
		.DEPTH(RECORD_BYTES)
	) u_buf (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	ihf_pack u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.sym_valid(sym_valid),
		.sym_ready(sym_ready),
		.sym      (sym),
		.text     (text)
	);

endmodule
